// ===== src/pfmt_pkg.sv =====
package pfmt_pkg;

    // Parser modes, one-hot
    typedef enum logic [5:0] {
        M_PLAIN = 6'b000001,
        M_PCT   = 6'b000010,
        M_L1    = 6'b000100,
        M_L2    = 6'b001000,
        M_WAIT  = 6'b010000,
        M_STOP  = 6'b100000
    } t_mode;

    typedef enum logic [1:0] {
        CV_SDEC = 2'd0,
        CV_UDEC = 2'd1,
        CV_HEXL = 2'd2,
        CV_HEXU = 2'd3
    } t_conv;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LD    = 8'h64;
    localparam logic [7:0] CH_LI    = 8'h69;
    localparam logic [7:0] CH_LL    = 8'h6c;
    localparam logic [7:0] CH_LU    = 8'h75;
    localparam logic [7:0] CH_LX    = 8'h78;

    // Digit stack: ten decimal digits at most
    localparam int STK_DEPTH = 10;
    localparam int SP_W      = 4;

    // floor(v / 10) == (v * DIV10_MAGIC) >> DIV10_SHIFT for any 32-bit v
    localparam logic [31:0] DIV10_MAGIC = 32'hcccccccd;
    localparam int          DIV10_SHIFT = 35;

    // Microcode
    typedef logic [2:0] t_step;

    typedef enum logic [2:0] {
        EM_NONE  = 3'd0,
        EM_MINUS = 3'd1,
        EM_ZERO  = 3'd2,
        EM_X     = 3'd3,
        EM_DIGIT = 3'd4
    } t_emit_sel;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_NEG  = 2'd1,
        OP_DIV  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        JC_NEXT     = 2'd0,
        JC_NOT_NEG  = 2'd1,
        JC_QUOT_NZ  = 2'd2,
        JC_STACK_NZ = 2'd3
    } t_cond;

    typedef struct packed {
        t_emit_sel emit;
        t_op       op;
        t_cond     cond;
        t_step     target;
        logic      fin;     // end of program when the jump is not taken
    } t_ucw;

    localparam t_step ST_SDEC    = 3'd0;
    localparam t_step ST_NEG     = 3'd1;
    localparam t_step ST_DEC_DIV = 3'd2;
    localparam t_step ST_DEC_POP = 3'd3;
    localparam t_step ST_HEX     = 3'd4;
    localparam t_step ST_HEX_X   = 3'd5;
    localparam t_step ST_HEX_DIV = 3'd6;
    localparam t_step ST_HEX_POP = 3'd7;

    function automatic t_ucw pfmt_ucode(input t_step a);
        t_ucw uc;
        case (a)
            ST_SDEC:    uc = '{EM_NONE,  OP_NONE, JC_NOT_NEG,  ST_DEC_DIV, 1'b0};
            ST_NEG:     uc = '{EM_MINUS, OP_NEG,  JC_NEXT,     ST_DEC_DIV, 1'b0};
            ST_DEC_DIV: uc = '{EM_NONE,  OP_DIV,  JC_QUOT_NZ,  ST_DEC_DIV, 1'b0};
            ST_DEC_POP: uc = '{EM_DIGIT, OP_NONE, JC_STACK_NZ, ST_DEC_POP, 1'b1};
            ST_HEX:     uc = '{EM_ZERO,  OP_NONE, JC_NEXT,     ST_HEX_X,   1'b0};
            ST_HEX_X:   uc = '{EM_X,     OP_NONE, JC_NEXT,     ST_HEX_DIV, 1'b0};
            ST_HEX_DIV: uc = '{EM_NONE,  OP_DIV,  JC_QUOT_NZ,  ST_HEX_DIV, 1'b0};
            default:    uc = '{EM_DIGIT, OP_NONE, JC_STACK_NZ, ST_HEX_POP, 1'b1};
        endcase
        return uc;
    endfunction

    function automatic t_step pfmt_entry(input t_conv c);
        t_step s;
        case (c)
            CV_SDEC: s = ST_SDEC;
            CV_UDEC: s = ST_DEC_DIV;
            default: s = ST_HEX;
        endcase
        return s;
    endfunction

    // One output word request
    typedef struct packed {
        logic       vld;
        logic [7:0] ch;
        logic       last;
        logic       err;
    } t_emit_word;

    // Sequencer -> datapath
    typedef struct packed {
        logic  load;
        t_conv conv;
        logic  neg;
        logic  div;
        logic  pop;
    } t_dp_ctl;

    // Datapath -> sequencer
    typedef struct packed {
        logic       neg;
        logic       quot_nz;
        logic       more;        // digits left after popping the top one
        logic [7:0] digit_char;
    } t_dp_sts;

endpackage

// ===== src/pfmt_if.sv =====
interface pfmt_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  format_char;
    logic [31:0] arg_value;

    modport source(output valid, action, format_char, arg_value, input ready);
    modport sink(input valid, action, format_char, arg_value, output ready);
endinterface

interface pfmt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;
    logic       protocol_error;

    modport source(output valid, out_char, last, protocol_error, input ready);
    modport sink(input valid, out_char, last, protocol_error, output ready);
endinterface

// ===== src/pfmt_parser.sv =====
module pfmt_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic                 i_action,
    input  logic [7:0]           i_char,
    output pfmt_pkg::t_emit_word o_emit,
    output logic                 o_start,
    output pfmt_pkg::t_conv      o_conv
);
    import pfmt_pkg::*;

    t_mode r_mode, n_mode;
    t_conv r_conv, n_conv;
    logic  r_seen, n_seen;
    logic  spec_ok;
    t_conv spec_conv;

    always_comb begin
        spec_ok   = 1'b1;
        spec_conv = CV_SDEC;
        case (i_char)
            CH_LD, CH_LI: spec_conv = CV_SDEC;
            CH_LU:        spec_conv = CV_UDEC;
            CH_LX:        spec_conv = CV_HEXL;
            CH_UX:        spec_conv = CV_HEXU;
            default:      spec_ok   = 1'b0;
        endcase
    end

    always_comb begin
        n_mode  = r_mode;
        n_conv  = r_conv;
        n_seen  = r_seen;
        o_emit  = '0;
        o_start = 1'b0;
        if (i_take) begin
            if (i_action) begin
                if (r_mode == M_WAIT) begin
                    o_start = 1'b1;
                    n_mode  = M_PLAIN;
                    n_seen  = 1'b0;
                end
            end else if (r_mode == M_WAIT) begin
                // format word while an argument is due: flag it, keep waiting
                o_emit.vld  = 1'b1;
                o_emit.last = 1'b1;
                o_emit.err  = 1'b1;
            end else if (i_char == CH_NUL) begin
                n_mode = M_PLAIN;
                n_seen = 1'b0;
            end else begin
                case (r_mode)
                    M_PCT, M_L1, M_L2: begin
                        if (r_mode == M_PCT && i_char == CH_LL) begin
                            n_seen = 1'b1;
                            n_mode = M_L1;
                        end else if (r_mode != M_PCT && r_seen && i_char == CH_SPACE) begin
                            n_mode = M_STOP;
                            n_seen = 1'b0;
                        end else if (r_mode == M_L1 && i_char == CH_LL) begin
                            n_mode = M_L2;
                        end else begin
                            n_seen = 1'b0;
                            n_mode = M_PLAIN;
                            if (spec_ok) begin
                                n_mode = M_WAIT;
                                n_conv = spec_conv;
                            end
                        end
                    end
                    M_STOP: begin
                    end
                    default: begin
                        if (i_char == CH_PCT) begin
                            n_mode = M_PCT;
                            n_seen = 1'b0;
                        end else begin
                            n_mode      = M_PLAIN;
                            o_emit.vld  = 1'b1;
                            o_emit.ch   = i_char;
                            o_emit.last = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_PLAIN;
            r_conv <= CV_SDEC;
            r_seen <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_conv <= n_conv;
            r_seen <= n_seen;
        end
    end

    assign o_conv = r_conv;

endmodule

// ===== src/pfmt_dp.sv =====
module pfmt_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfmt_pkg::t_dp_ctl i_ctl,
    input  logic [31:0]       i_arg,
    output pfmt_pkg::t_dp_sts o_sts
);
    import pfmt_pkg::*;

    logic [31:0]     r_val;
    logic [SP_W-1:0] r_sp;
    logic [3:0]      r_stk [STK_DEPTH];
    logic            r_hex;
    logic            r_upper;

    logic [63:0]     prod;
    logic [31:0]     q10;
    logic [3:0]      tenq_lo;
    logic [3:0]      d10;
    logic [31:0]     quot;
    logic [3:0]      dig;
    logic [SP_W-1:0] top_idx;
    logic [3:0]      top;

    // divide by ten through the reciprocal; only the low nibble of 10*q is needed
    assign prod    = 64'(r_val) * 64'(DIV10_MAGIC);
    assign q10     = 32'(prod[63:DIV10_SHIFT]);
    assign tenq_lo = {q10[0], 3'b000} + {q10[2:0], 1'b0};
    assign d10     = r_val[3:0] - tenq_lo;

    assign quot = r_hex ? {4'b0000, r_val[31:4]} : q10;
    assign dig  = r_hex ? r_val[3:0] : d10;

    assign top_idx = r_sp - SP_W'(1);
    assign top     = r_stk[top_idx];

    always_comb begin
        o_sts.neg     = r_val[31];
        o_sts.quot_nz = |quot;
        o_sts.more    = (r_sp != SP_W'(1));
        if (top < 4'd10) begin
            o_sts.digit_char = CH_ZERO + {4'b0000, top};
        end else begin
            o_sts.digit_char = (r_upper ? CH_UA : CH_LA) + {4'b0000, top} - 8'd10;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (i_ctl.load) begin
            r_sp <= '0;
        end else if (i_ctl.div) begin
            r_sp <= r_sp + SP_W'(1);
        end else if (i_ctl.pop) begin
            r_sp <= r_sp - SP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_val   <= i_arg;
            r_hex   <= (i_ctl.conv == CV_HEXL) || (i_ctl.conv == CV_HEXU);
            r_upper <= (i_ctl.conv == CV_HEXU);
        end else if (i_ctl.neg) begin
            r_val <= ~r_val + 32'd1;
        end else if (i_ctl.div) begin
            r_val       <= quot;
            r_stk[r_sp] <= dig;
        end
    end

endmodule

// ===== src/pfmt_seq.sv =====
module pfmt_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  pfmt_pkg::t_conv      i_conv,
    input  logic                 i_out_free,
    input  pfmt_pkg::t_dp_sts    i_sts,
    output logic                 o_busy,
    output pfmt_pkg::t_dp_ctl    o_ctl,
    output pfmt_pkg::t_emit_word o_emit
);
    import pfmt_pkg::*;

    logic  r_busy, n_busy;
    t_step r_step, n_step;
    t_ucw  ucw;
    logic  stall;
    logic  taken;

    assign ucw = pfmt_ucode(r_step);

    always_comb begin
        n_busy     = r_busy;
        n_step     = r_step;
        stall      = 1'b0;
        taken      = 1'b0;
        o_ctl      = '0;
        o_ctl.conv = i_conv;
        o_emit     = '0;
        if (i_start) begin
            o_ctl.load = 1'b1;
            n_busy     = 1'b1;
            n_step     = pfmt_entry(i_conv);
        end else if (r_busy) begin
            // a step that emits holds until the output register is free
            stall = (ucw.emit != EM_NONE) && !i_out_free;
            if (!stall) begin
                case (ucw.cond)
                    JC_NOT_NEG:  taken = !i_sts.neg;
                    JC_QUOT_NZ:  taken = i_sts.quot_nz;
                    JC_STACK_NZ: taken = i_sts.more;
                    default:     taken = 1'b0;
                endcase
                o_ctl.neg = (ucw.op == OP_NEG);
                o_ctl.div = (ucw.op == OP_DIV);
                o_ctl.pop = (ucw.emit == EM_DIGIT);
                if (ucw.emit != EM_NONE) begin
                    o_emit.vld  = 1'b1;
                    o_emit.last = ucw.fin && !taken;
                    case (ucw.emit)
                        EM_MINUS: o_emit.ch = CH_MINUS;
                        EM_ZERO:  o_emit.ch = CH_ZERO;
                        EM_X:     o_emit.ch = CH_LX;
                        default:  o_emit.ch = i_sts.digit_char;
                    endcase
                end
                if (taken) begin
                    n_step = ucw.target;
                end else if (ucw.fin) begin
                    n_busy = 1'b0;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= ST_SDEC;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    assign o_busy = r_busy;

endmodule

// ===== src/printf_integer_formatter.sv =====
// A format word's output, if any, is in the output register in the cycle after accept.
// An argument is loaded, then runs its prefix steps, one divide step per digit, one pop
//   step per digit. Prefix: none unsigned, sign test signed non-negative, sign test and '-'
//   signed negative, "0x" hex; -2147483648 is the longest. The microcode sequencer sets
//   the pace: one step per cycle unless an emitting step stalls, one digit per divide step.
// Reset: synchronous, active low; plain text mode, output register empty.
module printf_integer_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfmt_in_if.sink     i_in,
    pfmt_out_if.source  o_out
);
    import pfmt_pkg::*;

    logic       take;
    logic       out_free;
    logic       seq_busy;
    logic       par_start;
    t_conv      par_conv;
    t_emit_word par_emit;
    t_emit_word seq_emit;
    t_emit_word sel_emit;
    t_dp_ctl    dp_ctl;
    t_dp_sts    dp_sts;

    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_last;
    logic       r_out_err;

    // The output register may be refilled in the cycle its word leaves.
    assign out_free   = !r_out_valid || o_out.ready;
    // A new word is taken only while no conversion runs and a result can be held.
    assign i_in.ready = !seq_busy && out_free;
    assign take       = i_in.valid && i_in.ready;

    // Parser: one format word per cycle while the input is ready; updates mode and launches conversions.
    pfmt_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_action (i_in.action),
        .i_char   (i_in.format_char),
        .o_emit   (par_emit),
        .o_start  (par_start),
        .o_conv   (par_conv)
    );

    // Sequencer: steps through the control store and drives the digit datapath.
    pfmt_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (par_start),
        .i_conv     (par_conv),
        .i_out_free (out_free),
        .i_sts      (dp_sts),
        .o_busy     (seq_busy),
        .o_ctl      (dp_ctl),
        .o_emit     (seq_emit)
    );

    // Datapath: value register, divide by base, digit stack (pushed LSB first).
    pfmt_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dp_ctl),
        .i_arg   (i_in.arg_value),
        .o_sts   (dp_sts)
    );

    // Parser and sequencer never emit in the same cycle: the parser only
    // sees words while the sequencer is idle.
    assign sel_emit = seq_emit.vld ? seq_emit : par_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (sel_emit.vld) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sel_emit.vld) begin
            r_out_char <= sel_emit.ch;
            r_out_last <= sel_emit.last;
            r_out_err  <= sel_emit.err;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_char       = r_out_char;
    assign o_out.last           = r_out_last;
    assign o_out.protocol_error = r_out_err;

endmodule
